// ===== rtl/core/ndc_pkg.sv =====
// ndc_pkg: modes, character codes, digit limits and the status bundle of the
// binary to BCD unit. No dependencies.
`default_nettype none

package ndc_pkg;

    typedef enum logic [1:0] {
        MODE_UDEC = 2'd0,
        MODE_SDEC = 2'd1,
        MODE_HEX  = 2'd2,
        MODE_BIN  = 2'd3
    } mode_t;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_A     = 7'h41;
    localparam logic [6:0] CHAR_PLUS  = 7'h2B;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;

    localparam logic [4:0] MAX_DEC_DIGITS = 5'd10;
    localparam logic [4:0] MAX_HEX_DIGITS = 5'd8;
    localparam logic [4:0] MAX_BIN_DIGITS = 5'd16;

    localparam int unsigned BIN_WIDTH = 32;
    localparam int unsigned BCD_WIDTH = 40;

    typedef struct packed {
        logic busy;
        logic done;
    } bcd_stat_t;

endpackage : ndc_pkg

`default_nettype wire

// ===== rtl/core/ndc_bcd.sv =====
// ndc_bcd: iterative binary to BCD converter (shift and add three),
// one bit per cycle. Depends on ndc_pkg.
`default_nettype none

module ndc_bcd
    import ndc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [BIN_WIDTH-1:0] value,
    output bcd_stat_t                 stat,
    output logic [BCD_WIDTH-1:0]      bcd
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [BIN_WIDTH-1:0] bin_reg, bin_next;
    logic [BCD_WIDTH-1:0] bcd_reg, bcd_next;
    logic [BCD_WIDTH-1:0] adj;

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < BCD_WIDTH / 4; i++) begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                            bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            bin_next  = value;
            bcd_next  = '0;
        end else if (busy_reg) begin
            bcd_next = {adj[BCD_WIDTH-2:0], bin_reg[BIN_WIDTH-1]};
            bin_next = {bin_reg[BIN_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign bcd       = bcd_reg;

endmodule : ndc_bcd

`default_nettype wire

// ===== rtl/core/number_to_digit_characters.sv =====
// number_to_digit_characters: top level, sequencer and character output
// register. Depends on ndc_pkg and ndc_bcd.
`default_nettype none

// Takes one 32-bit number with a mode, display line, start column and digit
// count, and returns one ASCII character per output transfer, most
// significant digit first, with leading zeros kept and higher digits dropped.
// Modes: unsigned decimal, signed decimal (a '+' or '-' comes first at the
// start column), uppercase hex and binary (low bits only). The count
// saturates at 10, 10, 8 and 16 by mode. Decimal modes run the magnitude
// through a shared shift-and-add-three BCD unit, one bit per cycle, before the
// first character; hex and binary start straight away. Characters then
// leave at one per cycle while m_ready is high. In decimal the item is taken,
// the BCD unit makes 32 shifts and the done flag is picked up; in hex or
// binary the characters follow the taking of the item.
// s_ready is high only between items; the final character may still sit in
// the output register while the next item is taken.

module number_to_digit_characters
    import ndc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [2:0]  s_line,
    input  wire logic [4:0]  s_column,
    input  wire logic [31:0] s_number,
    input  wire logic [4:0]  s_length,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_line_out,
    output logic [5:0]       m_column_out,
    output logic [6:0]       m_char_code,
    output logic             m_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_OUT
    } state_t;

    state_t      state_reg;
    mode_t       mode_reg;
    logic [2:0]  line_reg;
    logic [5:0]  col_reg;
    logic [31:0] num_reg;
    logic [4:0]  cnt_reg;       // digits still to send
    logic        sign_pend_reg; // sign character still to send
    logic        neg_reg;

    logic        m_valid_reg;
    logic [2:0]  m_line_reg;
    logic [5:0]  m_col_reg;
    logic [6:0]  m_char_reg;
    logic        m_last_reg;

    // input side
    logic        s_xfer;
    mode_t       in_mode;
    logic [4:0]  len_limit;
    logic [4:0]  len_sat;
    logic        in_neg;
    logic [31:0] in_mag;

    // BCD unit
    logic             bcd_start;
    bcd_stat_t        bcd_stat;
    logic [BCD_WIDTH-1:0] bcd_data;

    // digit selection
    logic [4:0]  cnt_m1;
    logic [3:0]  k_idx;
    logic [5:0]  dec_bit;
    logic [4:0]  hex_bit;
    logic [63:0] bcd_pad;
    logic [15:0] bin_low;
    logic [3:0]  digit;
    logic [6:0]  digit_char;
    logic        out_free;
    logic        out_load;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;
    assign in_mode = mode_t'(s_mode);

    always_comb begin
        unique case (in_mode)
            MODE_HEX: len_limit = MAX_HEX_DIGITS;
            MODE_BIN: len_limit = MAX_BIN_DIGITS;
            default:  len_limit = MAX_DEC_DIGITS;
        endcase
    end

    assign len_sat   = (s_length > len_limit) ? len_limit : s_length;
    assign in_neg    = (in_mode == MODE_SDEC) && s_number[31];
    assign in_mag    = in_neg ? (32'd0 - s_number) : s_number;
    assign bcd_start = s_xfer && ((in_mode == MODE_UDEC) || (in_mode == MODE_SDEC));

    ndc_bcd u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (bcd_start),
        .value   (in_mag),
        .stat    (bcd_stat),
        .bcd     (bcd_data)
    );

    // digit k counts down from the top of the run
    assign cnt_m1  = cnt_reg - 5'd1;
    assign k_idx   = cnt_m1[3:0];
    assign dec_bit = {k_idx, 2'b00};
    assign hex_bit = {k_idx[2:0], 2'b00};
    assign bcd_pad = {{(64 - BCD_WIDTH){1'b0}}, bcd_data};
    assign bin_low = num_reg[15:0];

    always_comb begin
        unique case (mode_reg)
            MODE_HEX: digit = num_reg[hex_bit +: 4];
            MODE_BIN: digit = {3'b000, bin_low[k_idx]};
            default:  digit = bcd_pad[dec_bit +: 4];
        endcase
        if (digit >= 4'd10) begin
            digit_char = CHAR_A + {3'b000, digit} - 7'd10;
        end else begin
            digit_char = CHAR_ZERO + {3'b000, digit};
        end
    end

    // output register is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_OUT) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            sign_pend_reg <= 1'b0;
            cnt_reg       <= 5'd0;
        end else begin
            // a new character replaces the one leaving, else a drain empties it
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        mode_reg      <= in_mode;
                        line_reg      <= s_line;
                        col_reg       <= {1'b0, s_column};
                        num_reg       <= in_mag;
                        neg_reg       <= in_neg;
                        cnt_reg       <= len_sat;
                        sign_pend_reg <= (in_mode == MODE_SDEC);
                        if (bcd_start) begin
                            state_reg <= ST_CONV;
                        end else if (len_sat != 5'd0) begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_CONV: begin
                    if (bcd_stat.done) begin
                        // signed always has its sign; unsigned may have nothing
                        if (sign_pend_reg || (cnt_reg != 5'd0)) begin
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_line_reg  <= line_reg;
                        m_col_reg   <= col_reg;
                        col_reg     <= col_reg + 6'd1;
                        if (sign_pend_reg) begin
                            sign_pend_reg <= 1'b0;
                            m_char_reg    <= neg_reg ? CHAR_MINUS : CHAR_PLUS;
                            m_last_reg    <= (cnt_reg == 5'd0);
                            if (cnt_reg == 5'd0) begin
                                state_reg <= ST_IDLE;
                            end
                        end else begin
                            cnt_reg    <= cnt_m1;
                            m_char_reg <= digit_char;
                            m_last_reg <= (cnt_reg == 5'd1);
                            if (cnt_reg == 5'd1) begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_line_out   = m_line_reg;
    assign m_column_out = m_col_reg;
    assign m_char_code  = m_char_reg;
    assign m_last       = m_last_reg;

    // BCD unit only runs while the sequencer waits on it
    a_bcd_in_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        bcd_stat.busy |-> (state_reg == ST_CONV))
        else $error("BCD unit busy outside conversion");

    // emit state always has a character left to send
    a_out_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> (sign_pend_reg || (cnt_reg != 5'd0)))
        else $error("emit state with nothing left");

    // column stays within start column plus sign and sixteen digits
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_column_out <= 6'd47))
        else $error("column out of range");

    // only digits, A to F and signs leave the block
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (((m_char_code >= CHAR_ZERO) && (m_char_code <= CHAR_ZERO + 7'd9))
                  || ((m_char_code >= CHAR_A) && (m_char_code <= CHAR_A + 7'd5))
                  || (m_char_code == CHAR_PLUS) || (m_char_code == CHAR_MINUS)))
        else $error("illegal character code");

endmodule : number_to_digit_characters

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for number_to_digit_characters, with a directed table and then
// random numbers, modes, lines, columns and lengths, most of it under random idling on both channels.
// Depends on ndc_pkg and the number_to_digit_characters RTL.

module testbench;
    import ndc_pkg::*;

    localparam int N_RANDOM    = 286;     // directed rows bring the total to about 310
    localparam int LONG_HOLD   = 200;     // cycles the receiver sits with m_ready low
    localparam int SETTLE      = 64;      // one decimal item plus a full run of characters
    localparam int CYCLE_LIMIT = 400000;

    // One input item, as it goes onto the s_ ports.
    typedef struct packed {
        mode_t       mode;
        logic [2:0]  line;
        logic [4:0]  column;
        logic [31:0] number;
        logic [4:0]  length;
    } number_req_t;

    // One character on the output channel.
    typedef struct packed {
        logic [2:0] line;
        logic [5:0] column;
        logic [6:0] code;
        logic       last;
    } disp_char_t;

    // A directed row: where typed is set, text is the exact run of characters
    // expected, otherwise the row goes through the predictor.
    typedef struct {
        number_req_t req;
        bit          typed;
        string       text;
    } stim_row_t;

    localparam int N_DIRECTED = 24;

    stim_row_t directed_rows [N_DIRECTED] = '{
        // mode       line  col    number         len      typed  text
        '{'{MODE_UDEC, 3'd1, 5'd1,  32'h0000_0000, 5'd1},  1'b1, "0"},
        '{'{MODE_UDEC, 3'd4, 5'd16, 32'hFFFF_FFFF, 5'd10}, 1'b1, "4294967295"},
        '{'{MODE_UDEC, 3'd2, 5'd3,  32'hFFFF_FFFF, 5'd31}, 1'b1, "4294967295"},
        '{'{MODE_UDEC, 3'd3, 5'd5,  32'd12345,     5'd0},  1'b1, ""},
        '{'{MODE_UDEC, 3'd1, 5'd2,  32'd1234567,   5'd3},  1'b1, "567"},
        '{'{MODE_UDEC, 3'd2, 5'd8,  32'd42,        5'd5},  1'b1, "00042"},
        '{'{MODE_SDEC, 3'd1, 5'd1,  32'h8000_0000, 5'd10}, 1'b1, "-2147483648"},
        '{'{MODE_SDEC, 3'd2, 5'd4,  32'h7FFF_FFFF, 5'd10}, 1'b1, "+2147483647"},
        '{'{MODE_SDEC, 3'd3, 5'd6,  32'h0000_0000, 5'd0},  1'b1, "+"},
        '{'{MODE_SDEC, 3'd4, 5'd9,  32'hFFFF_FFFF, 5'd0},  1'b1, "-"},
        '{'{MODE_SDEC, 3'd1, 5'd12, 32'hFFFF_FFFF, 5'd3},  1'b1, "-001"},
        '{'{MODE_SDEC, 3'd7, 5'd31, 32'h8000_0000, 5'd20}, 1'b1, "-2147483648"},
        '{'{MODE_HEX,  3'd1, 5'd1,  32'hDEAD_BEEF, 5'd8},  1'b1, "DEADBEEF"},
        '{'{MODE_HEX,  3'd2, 5'd7,  32'h0123_ABCD, 5'd31}, 1'b1, "0123ABCD"},
        '{'{MODE_HEX,  3'd3, 5'd2,  32'hFFFF_FFFF, 5'd0},  1'b1, ""},
        '{'{MODE_HEX,  3'd4, 5'd10, 32'h89AB_CDEF, 5'd4},  1'b1, "CDEF"},
        '{'{MODE_BIN,  3'd1, 5'd1,  32'hFFFF_5A5A, 5'd16}, 1'b1, "0101101001011010"},
        '{'{MODE_BIN,  3'd2, 5'd16, 32'hFFFF_FFFF, 5'd31}, 1'b1, "1111111111111111"},
        '{'{MODE_BIN,  3'd3, 5'd4,  32'h0000_0000, 5'd0},  1'b1, ""},
        '{'{MODE_BIN,  3'd0, 5'd0,  32'h0000_0005, 5'd3},  1'b1, "101"},
        '{'{MODE_SDEC, 3'd7, 5'd31, 32'h1234_5678, 5'd16}, 1'b0, ""},
        '{'{MODE_UDEC, 3'd0, 5'd0,  32'hAAAA_AAAA, 5'd16}, 1'b0, ""},
        '{'{MODE_HEX,  3'd5, 5'd21, 32'h5555_5555, 5'd7},  1'b0, ""},
        '{'{MODE_BIN,  3'd6, 5'd10, 32'h0000_00A5, 5'd8},  1'b0, ""}
    };

    // Clock, reset and every block input start at known values.
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_valid  = 1'b0;
    logic [1:0]  s_mode   = '0;
    logic [2:0]  s_line   = '0;
    logic [4:0]  s_column = '0;
    logic [31:0] s_number = '0;
    logic [4:0]  s_length = '0;
    logic        m_ready  = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [2:0]  m_line_out;
    logic [5:0]  m_column_out;
    logic [6:0]  m_char_code;
    logic        m_last;

    disp_char_t  chars_due [$];       // characters still owed by the block, oldest first
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          hold_rx        = 1'b0;  // asks the receiver for one long hold-off
    bit          calm           = 1'b0;  // no idling on either side while set

    always #4ns aclk = ~aclk;

    number_to_digit_characters u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_line       (s_line),
        .s_column     (s_column),
        .s_number     (s_number),
        .s_length     (s_length),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_line_out   (m_line_out),
        .m_column_out (m_column_out),
        .m_char_code  (m_char_code),
        .m_last       (m_last)
    );

    // Predictor: queues the characters one number turns into. Digits are
    // peeled off least significant first, then sent out in reverse.
    task automatic spell_number(input number_req_t r);
        int          cap;
        int          n;
        int          i;
        logic [5:0]  col;
        logic [31:0] mag;
        logic [3:0]  digit [16];
        logic [3:0]  d;
        disp_char_t  c;
        case (r.mode)
            MODE_HEX: cap = MAX_HEX_DIGITS;
            MODE_BIN: cap = MAX_BIN_DIGITS;
            default:  cap = MAX_DEC_DIGITS;
        endcase
        n   = (r.length > cap) ? cap : r.length;
        col = {1'b0, r.column};
        mag = r.number;
        if (r.mode == MODE_SDEC) begin
            // sign sits at the start column, magnitude one further right
            c.line   = r.line;
            c.column = col;
            c.code   = r.number[31] ? CHAR_MINUS : CHAR_PLUS;
            c.last   = (n == 0);
            chars_due.push_back(c);
            if (r.number[31]) begin
                mag = -r.number;    // most negative value wraps to 2^31, which is right
            end
            col = col + 6'd1;
        end
        for (i = 0; i < n; i++) begin
            case (r.mode)
                MODE_HEX: begin
                    digit[i] = mag[3:0];
                    mag      = mag >> 4;
                end
                MODE_BIN: begin
                    digit[i] = {3'b000, mag[0]};
                    mag      = mag >> 1;
                end
                default: begin
                    digit[i] = 4'(mag % 10);
                    mag      = mag / 10;
                end
            endcase
        end
        for (i = 0; i < n; i++) begin
            d        = digit[n - 1 - i];
            c.line   = r.line;
            c.column = col + 6'(i);
            c.code   = (d < 4'd10) ? CHAR_ZERO + 7'(d) : CHAR_A + 7'(d) - 7'd10;
            c.last   = (i == n - 1);
            chars_due.push_back(c);
        end
    endtask

    // Typed rows: the text is the run of characters, columns counting up
    // from the start column.
    task automatic queue_text(input stim_row_t row);
        int         i;
        disp_char_t c;
        for (i = 0; i < row.text.len(); i++) begin
            c.line   = row.req.line;
            c.column = {1'b0, row.req.column} + 6'(i);
            c.code   = 7'(row.text[i]);
            c.last   = (i == row.text.len() - 1);
            chars_due.push_back(c);
        end
    endtask

    // Mostly lengths the mode can show, some zero, some past saturation;
    // numbers lean on the sign boundary and short values now and then.
    function automatic number_req_t random_request();
        number_req_t r;
        int          cap;
        int          pick;
        r.mode   = mode_t'($urandom_range(0, 3));
        r.line   = 3'($urandom_range(0, 7));
        r.column = 5'($urandom_range(0, 31));
        case (r.mode)
            MODE_HEX: cap = MAX_HEX_DIGITS;
            MODE_BIN: cap = MAX_BIN_DIGITS;
            default:  cap = MAX_DEC_DIGITS;
        endcase
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            r.length = 5'd0;
        end else if (pick == 1) begin
            r.length = 5'($urandom_range(cap + 1, 31));
        end else begin
            r.length = 5'($urandom_range(1, cap));
        end
        pick = $urandom_range(0, 9);
        case (pick)
            0:       r.number = 32'h8000_0000;
            1:       r.number = 32'h7FFF_FFFF;
            2:       r.number = $urandom_range(0, 999);
            3:       r.number = -$urandom_range(1, 999);
            4:       r.number = (pick[0]) ? 32'hFFFF_FFFF : 32'h0000_0000;
            default: r.number = $urandom;
        endcase
        if (pick == 4 && $urandom_range(0, 1) == 1) begin
            r.number = 32'hFFFF_FFFF;
        end
        return r;
    endfunction

    // Offer one item after a random gap and return at the edge of its
    // transfer. A zero gap keeps s_valid high straight into the next item.
    task automatic offer(input number_req_t r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_mode   <= r.mode;
        s_line   <= r.line;
        s_column <= r.column;
        s_number <= r.number;
        s_length <= r.length;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // Drop valid and sit until the block owes nothing. Always waits on a clock
    // edge, so valid is never lowered and raised in one step.
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (chars_due.size() != 0);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver: random stall before each character, plus one long hold-off
    // on request, counted here, so the block backs up into s_ready.
    initial begin : receiver
        int gap;
        forever begin
            if (hold_rx) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_rx = 1'b0;
            end
            gap = calm ? 0 : $urandom_range(0, 4);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Every output transfer is matched against the oldest character owed.
    always @(posedge aclk) begin : char_monitor
        disp_char_t want;
        if (aresetn && m_valid && m_ready) begin
            if (chars_due.size() == 0) begin
                $display("%0t: unexpected character: line %0d column %0d code %h last %b",
                         $time, m_line_out, m_column_out, m_char_code, m_last);
                mismatch_count++;
            end else begin
                want = chars_due.pop_front();
                check_field("line_out",   want.line,   m_line_out);
                check_field("column_out", want.column, m_column_out);
                check_field("char_code",  want.code,   m_char_code);
                check_field("last",       want.last,   m_last);
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        int          k;
        number_req_t req;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table: extremes, every mode, saturation, zero length,
        // the most negative signed value and higher digits being dropped.
        for (k = 0; k < N_DIRECTED; k++) begin
            offer(directed_rows[k].req);
            if (directed_rows[k].typed) begin
                queue_text(directed_rows[k]);
            end else begin
                spell_number(directed_rows[k].req);
            end
        end
        pause_until_drained();

        // Random part. Opens with the long receiver hold while items keep
        // coming; two stretches run with no idling; one full drain midway.
        for (k = 0; k < N_RANDOM; k++) begin
            if (k == 0) begin
                hold_rx = 1'b1;
            end
            if (k == 150) begin
                pause_until_drained();
            end
            calm = (k >= 60 && k < 100) || (k >= 200 && k < 230);
            req  = random_request();
            offer(req);
            spell_number(req);
        end
        calm = 1'b0;

        // Wait for the last characters, then a little longer for strays.
        pause_until_drained();
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
